// ----- hw/rtl/rcsk_pkg.sv -----
// Package for the realtime clock slew keeper: payload types, register codes and constants.
package rcsk_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_FREQ  = 3'd0,
        CFG_NSEC_SCALE  = 3'd1,
        CFG_SLEW_STEP   = 3'd2,
        CFG_SLEW_TOTAL  = 3'd3,
        CFG_FRAC_ADJUST = 3'd4,
        CFG_BASE_SEC    = 3'd5,
        CFG_BASE_NSEC   = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic        mode;
        logic [31:0] timer_count;
    } t_in;

    typedef struct packed {
        logic [33:0] real_seconds;
        logic [29:0] real_nanoseconds;
        logic        second_rolled;
        logic        slew_active;
    } t_out;

    localparam logic        MODE_TICK = 1'b0;

    localparam logic [31:0] TIMER_FREQ_RST = 32'd1000000;
    localparam logic [63:0] NSEC_SCALE_RST = 64'd4294967296000;
    localparam logic [33:0] UPTIME_RST     = 34'd1;

    localparam logic [29:0] NS_PER_SEC      = 30'd1000000000;
    localparam logic [29:0] NS_MAX          = 30'd999999999;
    localparam logic signed [31:0] NS_PER_SEC_S = 32'sd1000000000;
    localparam logic signed [27:0] NS_PER_US    = 28'sd1000;

    localparam logic signed [49:0] FRAC_ONE     = 50'sh1_0000_0000;
    localparam logic signed [49:0] FRAC_NEG_ONE = -50'sh1_0000_0000;

    // Multiples of one second in nanoseconds for the final carry.
    localparam logic [32:0] NS_X1 = 33'd1000000000;
    localparam logic [32:0] NS_X2 = 33'd2000000000;
    localparam logic [32:0] NS_X3 = 33'd3000000000;
    localparam logic [32:0] NS_X4 = 33'd4000000000;
    localparam logic [32:0] NS_X5 = 33'd5000000000;

endpackage

// ----- hw/rtl/realtime_clock_slew_keeper.sv -----
// Realtime clock slew keeper: time-of-day clock with slew and fractional frequency trim.
// Requests are accepted one per cycle unless a result stall backs up the pipeline.
// The stages, in order to the output register, are the state update, the two
// 32x32 partial products of scale and delta, the nanosecond sum and the carry by 1e9.
// Synchronous active-low reset empties the pipeline, loads the default registers
// and sets uptime to one second with zero offset, slew and trim accumulator.
module realtime_clock_slew_keeper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rcsk_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rcsk_pkg::t_out                      o_out,
    input  logic                                i_cfg_we,
    input  logic [rcsk_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rcsk_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [31:0]        r_timer_freq;
    logic [63:0]        r_nsec_scale;
    logic signed [17:0] r_slew_step;
    logic signed [48:0] r_frac_adj;

    // Clock state.
    logic [33:0]        r_uptime;
    logic [31:0]        r_timer_base;
    logic [33:0]        r_offset_sec;
    logic [29:0]        r_offset_ns;
    logic [40:0]        r_slew_rem;
    logic signed [32:0] r_frac_accum;

    // Pipeline.
    logic               r_v1, r_v2, r_v3, r_v4;
    logic [31:0]        r_s1_delta;
    logic [33:0]        r_s1_sec, r_s2_sec, r_s3_sec;
    logic [29:0]        r_s1_ns_off, r_s2_ns_off;
    logic               r_s1_rolled, r_s2_rolled, r_s3_rolled;
    logic               r_s1_slew, r_s2_slew, r_s3_slew;
    logic [63:0]        r_s2_plo;
    logic [31:0]        r_s2_phi;
    logic [32:0]        r_s3_ns;
    rcsk_pkg::t_out     r_out;

    logic               w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic               w_accept, w_tick;

    logic [31:0]        w_delta, w_delta_s1;
    logic               w_roll, w_slew_on;
    logic signed [27:0] w_step_ns;
    logic signed [49:0] w_fsum;
    logic [49:0]        w_fmag;
    logic signed [17:0] w_fadd;
    logic signed [31:0] w_nsv;

    logic [33:0]        n_uptime;
    logic [31:0]        n_timer_base;
    logic [33:0]        n_offset_sec;
    logic [29:0]        n_offset_ns;
    logic [40:0]        n_slew_rem;
    logic signed [32:0] n_frac_accum;

    logic [63:0]        w_plo;
    logic [31:0]        w_phi;
    logic [31:0]        w_ns_frac;
    logic [32:0]        w_ns_sum;
    logic [2:0]         w_quot;
    logic [32:0]        w_ns_rem;

    // A stage can take new data when it is empty or its content moves on.
    assign w_rdy4     = !r_v4 || !i_out_stall;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1;
    assign w_accept   = i_in_valid && w_rdy1;
    assign w_tick     = (i_in.mode == rcsk_pkg::MODE_TICK);

    // State after this request; a read leaves everything as it is.
    assign w_delta      = i_in.timer_count - r_timer_base;
    assign w_roll       = w_tick && (w_delta > r_timer_freq);
    assign n_uptime     = w_roll ? r_uptime + 34'd1 : r_uptime;
    assign n_timer_base = w_roll ? r_timer_base + r_timer_freq : r_timer_base;
    assign w_delta_s1   = w_roll ? w_delta - r_timer_freq : w_delta;

    assign w_slew_on  = w_tick && (r_slew_rem != '0);
    assign n_slew_rem = w_slew_on ? r_slew_rem - {{23{r_slew_step[17]}}, r_slew_step}
                                  : r_slew_rem;
    assign w_step_ns  = w_slew_on ? 28'($signed(r_slew_step) * rcsk_pkg::NS_PER_US)
                                  : 28'sd0;

    assign w_fsum = 50'(r_frac_accum) + 50'(r_frac_adj);
    assign w_fmag = 50'(-w_fsum);

    always_comb begin
        w_fadd       = 18'sd0;
        n_frac_accum = r_frac_accum;
        if (w_tick && (r_frac_adj != '0)) begin
            priority if (w_fsum >= rcsk_pkg::FRAC_ONE) begin
                w_fadd       = $signed({1'b0, w_fsum[48:32]});
                n_frac_accum = $signed({1'b0, w_fsum[31:0]});
            end else if (w_fsum <= rcsk_pkg::FRAC_NEG_ONE) begin
                w_fadd       = -$signed({1'b0, w_fmag[48:32]});
                n_frac_accum = -$signed({1'b0, w_fmag[31:0]});
            end else begin
                n_frac_accum = w_fsum[32:0];
            end
        end
    end

    assign w_nsv = $signed({2'b00, r_offset_ns}) + 32'(w_step_ns) + 32'(w_fadd);

    // The offset stays within one second of range, so one correction is enough.
    always_comb begin
        priority if (w_nsv >= rcsk_pkg::NS_PER_SEC_S) begin
            n_offset_ns  = 30'(w_nsv - rcsk_pkg::NS_PER_SEC_S);
            n_offset_sec = r_offset_sec + 34'd1;
        end else if (w_nsv < 32'sd0) begin
            n_offset_ns  = 30'(w_nsv + rcsk_pkg::NS_PER_SEC_S);
            n_offset_sec = r_offset_sec - 34'd1;
        end else begin
            n_offset_ns  = w_nsv[29:0];
            n_offset_sec = r_offset_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_freq <= rcsk_pkg::TIMER_FREQ_RST;
            r_nsec_scale <= rcsk_pkg::NSEC_SCALE_RST;
            r_slew_step  <= '0;
            r_frac_adj   <= '0;
            r_uptime     <= rcsk_pkg::UPTIME_RST;
            r_timer_base <= '0;
            r_offset_sec <= '0;
            r_offset_ns  <= '0;
            r_slew_rem   <= '0;
            r_frac_accum <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rcsk_pkg::CFG_TIMER_FREQ:  r_timer_freq <= i_cfg_data[31:0];
                rcsk_pkg::CFG_NSEC_SCALE:  r_nsec_scale <= i_cfg_data;
                rcsk_pkg::CFG_SLEW_STEP:   r_slew_step  <= $signed(i_cfg_data[17:0]);
                rcsk_pkg::CFG_SLEW_TOTAL:  r_slew_rem   <= i_cfg_data[40:0];
                rcsk_pkg::CFG_FRAC_ADJUST: r_frac_adj   <= $signed(i_cfg_data[48:0]);
                rcsk_pkg::CFG_BASE_SEC:    r_offset_sec <= i_cfg_data[33:0];
                rcsk_pkg::CFG_BASE_NSEC: begin
                    r_offset_ns <= (i_cfg_data[29:0] >= rcsk_pkg::NS_PER_SEC)
                                   ? rcsk_pkg::NS_MAX : i_cfg_data[29:0];
                end
                default: ;
            endcase
        end else if (w_accept) begin
            r_uptime     <= n_uptime;
            r_timer_base <= n_timer_base;
            r_offset_sec <= n_offset_sec;
            r_offset_ns  <= n_offset_ns;
            r_slew_rem   <= n_slew_rem;
            r_frac_accum <= n_frac_accum;
        end
    end

    // Low 64 bits of scale times delta, from two 32x32 partial products.
    assign w_plo     = r_s1_delta * r_nsec_scale[31:0];
    assign w_phi     = r_s1_delta * r_nsec_scale[63:32];
    assign w_ns_frac = r_s2_plo[63:32] + r_s2_phi;
    assign w_ns_sum  = {1'b0, w_ns_frac} + {3'b000, r_s2_ns_off};

    // The nanosecond sum stays below six seconds.
    always_comb begin
        priority if (r_s3_ns >= rcsk_pkg::NS_X5) begin
            w_quot   = 3'd5;
            w_ns_rem = r_s3_ns - rcsk_pkg::NS_X5;
        end else if (r_s3_ns >= rcsk_pkg::NS_X4) begin
            w_quot   = 3'd4;
            w_ns_rem = r_s3_ns - rcsk_pkg::NS_X4;
        end else if (r_s3_ns >= rcsk_pkg::NS_X3) begin
            w_quot   = 3'd3;
            w_ns_rem = r_s3_ns - rcsk_pkg::NS_X3;
        end else if (r_s3_ns >= rcsk_pkg::NS_X2) begin
            w_quot   = 3'd2;
            w_ns_rem = r_s3_ns - rcsk_pkg::NS_X2;
        end else if (r_s3_ns >= rcsk_pkg::NS_X1) begin
            w_quot   = 3'd1;
            w_ns_rem = r_s3_ns - rcsk_pkg::NS_X1;
        end else begin
            w_quot   = 3'd0;
            w_ns_rem = r_s3_ns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_delta  <= w_delta_s1;
            r_s1_sec    <= n_uptime + n_offset_sec;
            r_s1_ns_off <= n_offset_ns;
            r_s1_rolled <= w_roll;
            r_s1_slew   <= (n_slew_rem != '0);
        end
        if (w_rdy2) begin
            r_s2_plo    <= w_plo;
            r_s2_phi    <= w_phi;
            r_s2_sec    <= r_s1_sec;
            r_s2_ns_off <= r_s1_ns_off;
            r_s2_rolled <= r_s1_rolled;
            r_s2_slew   <= r_s1_slew;
        end
        if (w_rdy3) begin
            r_s3_ns     <= w_ns_sum;
            r_s3_sec    <= r_s2_sec;
            r_s3_rolled <= r_s2_rolled;
            r_s3_slew   <= r_s2_slew;
        end
        if (w_rdy4) begin
            r_out.real_seconds     <= r_s3_sec + {31'd0, w_quot};
            r_out.real_nanoseconds <= w_ns_rem[29:0];
            r_out.second_rolled    <= r_s3_rolled;
            r_out.slew_active      <= r_s3_slew;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out       = r_out;

    a_offset_ns_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset_ns < rcsk_pkg::NS_PER_SEC)
        else $error("offset nanoseconds left the one-second range");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac_accum != {1'b1, 32'd0})
        else $error("trim accumulator holds a whole nanosecond");

    a_out_ns_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.real_nanoseconds < rcsk_pkg::NS_PER_SEC))
        else $error("reported nanoseconds not reduced below one second");

    a_read_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_tick) |=> ($stable(r_timer_base) && $stable(r_uptime)
                                   && $stable(r_frac_accum)))
        else $error("read request changed the clock state");

    a_read_no_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_tick && w_rdy2) |=> !r_s1_rolled)
        else $error("read request flagged a seconds rollover");

endmodule

// ----- test/rcsk_time_checker.sv -----
// Checker for the realtime clock slew keeper: predicts the time for each request and compares results.
`timescale 1ns / 1ps

module rcsk_time_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  rcsk_pkg::t_in                       i_in,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  rcsk_pkg::t_out                      i_out,
    input  logic                                i_cfg_we,
    input  logic [rcsk_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rcsk_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_pending,
    output int                                  o_fail_count
);

    localparam longint NSEC_PER_SEC  = 64'sd1000000000;
    localparam longint NSEC_MAX      = 64'sd999999999;
    localparam longint NSEC_PER_USEC = 64'sd1000;
    localparam longint FRAC_UNIT     = 64'sh1_0000_0000;
    localparam longint FRAC_FIELD    = 64'sh0_FFFF_FFFF;
    localparam int     REPORT_LINES  = 40;

    // Configuration copies.
    logic [31:0]        timer_freq;
    logic [63:0]        nsec_scale;
    logic signed [17:0] slew_step;
    logic signed [48:0] frac_trim;

    // Clock state.
    logic [33:0]        uptime_sec;
    logic [31:0]        timer_base;
    logic [33:0]        offset_sec;
    longint             offset_nsec;
    logic [40:0]        slew_left;
    longint             frac_accum;

    rcsk_pkg::t_out     expected_times[$];
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic clear_clock();
        timer_freq  = 32'd1000000;
        nsec_scale  = 64'd4294967296000;
        slew_step   = '0;
        frac_trim   = '0;
        uptime_sec  = 34'd1;
        timer_base  = '0;
        offset_sec  = '0;
        offset_nsec = 0;
        slew_left   = '0;
        frac_accum  = 0;
    endtask

    task automatic load_register(logic [rcsk_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        case (idx)
            rcsk_pkg::CFG_TIMER_FREQ:  timer_freq = data[31:0];
            rcsk_pkg::CFG_NSEC_SCALE:  nsec_scale = data;
            rcsk_pkg::CFG_SLEW_STEP:   slew_step  = data[17:0];
            rcsk_pkg::CFG_SLEW_TOTAL:  slew_left  = data[40:0];
            rcsk_pkg::CFG_FRAC_ADJUST: frac_trim  = data[48:0];
            rcsk_pkg::CFG_BASE_SEC:    offset_sec = data[33:0];
            rcsk_pkg::CFG_BASE_NSEC: begin
                // Out-of-range nanosecond loads saturate just below one second.
                if (longint'(data[29:0]) >= NSEC_PER_SEC) offset_nsec = NSEC_MAX;
                else offset_nsec = longint'(data[29:0]);
            end
            default: ;
        endcase
    endtask

    function automatic rcsk_pkg::t_out time_at_request(rcsk_pkg::t_in req);
        rcsk_pkg::t_out res;
        logic [31:0]    delta;
        logic [63:0]    prod;
        logic [63:0]    nsec_sum;
        logic [63:0]    sec_sum;
        longint         nsv;
        longint         mag;
        res = '0;
        if (req.mode == rcsk_pkg::MODE_TICK) begin
            nsv = offset_nsec;
            delta = req.timer_count - timer_base;
            if (delta > timer_freq) begin
                uptime_sec = uptime_sec + 34'd1;
                timer_base = timer_base + timer_freq;
                res.second_rolled = 1'b1;
            end
            if (slew_left != '0) begin
                nsv = nsv + longint'(slew_step) * NSEC_PER_USEC;
                slew_left = slew_left - 41'(longint'(slew_step));
            end
            if (frac_trim != '0) begin
                frac_accum = frac_accum + longint'(frac_trim);
                if (frac_accum >= FRAC_UNIT) begin
                    nsv = nsv + (frac_accum >>> 32);
                    frac_accum = frac_accum & FRAC_FIELD;
                end else if (frac_accum <= -FRAC_UNIT) begin
                    // Negative folds work on the magnitude so the remainder keeps its sign.
                    mag = -frac_accum;
                    nsv = nsv - (mag >>> 32);
                    frac_accum = -(mag & FRAC_FIELD);
                end
            end
            if (nsv >= NSEC_PER_SEC) begin
                nsv = nsv - NSEC_PER_SEC;
                offset_sec = offset_sec + 34'd1;
            end else if (nsv < 0) begin
                nsv = nsv + NSEC_PER_SEC;
                offset_sec = offset_sec - 34'd1;
            end
            offset_nsec = nsv;
        end
        delta = req.timer_count - timer_base;
        prod = nsec_scale * {32'd0, delta};
        nsec_sum = {32'd0, prod[63:32]} + 64'(offset_nsec);
        sec_sum = 64'(uptime_sec) + 64'(offset_sec) + nsec_sum / 64'd1000000000;
        res.real_seconds = sec_sum[33:0];
        res.real_nanoseconds = 30'(nsec_sum % 64'd1000000000);
        res.slew_active = (slew_left != '0);
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (fail_count < REPORT_LINES)
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        rcsk_pkg::t_out want;
        if (!i_rst_n) begin
            clear_clock();
            expected_times.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_times.size() == 0) begin
                    report_mismatch("unrequested result seconds", 64'(i_out.real_seconds), '0);
                end else begin
                    want = expected_times.pop_front();
                    if (i_out.real_seconds !== want.real_seconds)
                        report_mismatch("real_seconds", 64'(i_out.real_seconds),
                                        64'(want.real_seconds));
                    if (i_out.real_nanoseconds !== want.real_nanoseconds)
                        report_mismatch("real_nanoseconds", 64'(i_out.real_nanoseconds),
                                        64'(want.real_nanoseconds));
                    if (i_out.second_rolled !== want.second_rolled)
                        report_mismatch("second_rolled", 64'(i_out.second_rolled),
                                        64'(want.second_rolled));
                    if (i_out.slew_active !== want.slew_active)
                        report_mismatch("slew_active", 64'(i_out.slew_active),
                                        64'(want.slew_active));
                end
            end
            if (i_cfg_we)
                load_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall)
                expected_times.push_back(time_at_request(i_in));
        end
        o_pending <= expected_times.size();
    end

endmodule

// ----- test/realtime_clock_slew_keeper_tb.sv -----
// Testbench top for the realtime clock slew keeper: stimulus, idling, timeout and verdict.
`timescale 1ns / 1ps

module realtime_clock_slew_keeper_tb;

    localparam int     HALF_PERIOD   = 2;
    localparam int     RESET_CYCLES  = 11;
    localparam int     DRAIN_CYCLES  = 8;
    localparam int     RANDOM_EVENTS = 1000;
    localparam int     HOLD_CYCLES   = 150;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam logic   MODE_READ     = 1'b1;
    localparam logic [rcsk_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               req_valid;
    logic                               req_stall;
    rcsk_pkg::t_in                      req;
    logic                               res_valid;
    logic                               res_stall = 1'b0;
    rcsk_pkg::t_out                     res;
    logic                               cfg_we;
    logic [rcsk_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [rcsk_pkg::CFG_DATA_W-1:0]    cfg_data;

    int          pending;
    int          fail_count;
    int          hold_requests = 0;
    int          cycle_count = 0;
    logic        burst_mode = 1'b0;
    logic [31:0] timer_now;
    logic [31:0] cur_freq;

    always #(HALF_PERIOD) clk = ~clk;

    realtime_clock_slew_keeper dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in        (req),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rcsk_time_checker time_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_stall   (req_stall),
        .i_in         (req),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_out        (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, free-running stretches, and a long hold-off on request.
    initial begin : result_sink
        int   stall_left;
        int   free_left;
        int   hold_served;
        int   r;
        logic stall_next;
        stall_left  = 0;
        free_left   = 0;
        hold_served = 0;
        forever begin
            @(negedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_next = 1'b1;
                stall_left--;
            end else if (free_left > 0) begin
                stall_next = 1'b0;
                free_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    stall_next = ($urandom_range(0, 9) < 3);
                end else if (r < 80) begin
                    stall_next = 1'b0;
                    free_left = $urandom_range(5, 40);
                end else if (r < 97) begin
                    stall_next = 1'b1;
                    stall_left = $urandom_range(1, 4);
                end else begin
                    stall_next = 1'b1;
                    stall_left = $urandom_range(10, 40);
                end
            end
            res_stall <= stall_next;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_event(logic mode, logic [31:0] count);
        int            gap;
        rcsk_pkg::t_in item;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.mode = mode;
        item.timer_count = count;
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic program_reg(logic [rcsk_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int          phase;
        int          n;
        int          r;
        int          random_left;
        logic [31:0] span;
        logic [17:0] step;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default settings: no roll at exactly one second, roll just past it, widest delta.
        send_event(rcsk_pkg::MODE_TICK, 32'd0);
        send_event(MODE_READ, 32'hFFFF_FFFF);
        send_event(rcsk_pkg::MODE_TICK, 32'd1000000);
        send_event(rcsk_pkg::MODE_TICK, 32'd1000001);
        send_event(MODE_READ, 32'd1000001);

        // Seconds wrap and a saturating nanosecond load.
        settle();
        program_reg(rcsk_pkg::CFG_BASE_SEC, 64'h3_FFFF_FFFF);
        program_reg(rcsk_pkg::CFG_BASE_NSEC, 64'h3FFF_FFFF);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000002);
        send_event(MODE_READ, 32'd2999999);

        // Largest step, ending exactly at zero after three ticks.
        settle();
        program_reg(rcsk_pkg::CFG_SLEW_STEP, 64'h1FFFF);
        program_reg(rcsk_pkg::CFG_SLEW_TOTAL, 64'd393213);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000100);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000200);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000300);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000400);

        // Most negative step overshoots and keeps slewing.
        settle();
        program_reg(rcsk_pkg::CFG_SLEW_STEP, 64'h20000);
        program_reg(rcsk_pkg::CFG_SLEW_TOTAL, 64'd5);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000500);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000600);

        // A zero step with slew left never finishes.
        settle();
        program_reg(rcsk_pkg::CFG_SLEW_STEP, 64'd0);
        program_reg(rcsk_pkg::CFG_SLEW_TOTAL, 64'd1);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000700);
        settle();
        program_reg(rcsk_pkg::CFG_SLEW_TOTAL, 64'h100_0000_0000);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000800);

        // Trim extremes in both directions.
        settle();
        program_reg(rcsk_pkg::CFG_SLEW_TOTAL, 64'h0FF_FFFF_FFFF);
        program_reg(rcsk_pkg::CFG_FRAC_ADJUST, 64'h0000_FFFF_FFFF_FFFF);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000900);
        send_event(rcsk_pkg::MODE_TICK, 32'd2001000);
        settle();
        program_reg(rcsk_pkg::CFG_FRAC_ADJUST, 64'h0001_0000_0000_0000);
        send_event(rcsk_pkg::MODE_TICK, 32'd2001100);
        send_event(rcsk_pkg::MODE_TICK, 32'd2001200);

        // Zero frequency: the base sits at two million here, so the first tick has no delta.
        settle();
        program_reg(rcsk_pkg::CFG_TIMER_FREQ, 64'd0);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000000);
        send_event(rcsk_pkg::MODE_TICK, 32'd2000005);
        settle();
        program_reg(rcsk_pkg::CFG_TIMER_FREQ, 64'hFFFF_FFFF);
        send_event(rcsk_pkg::MODE_TICK, 32'hFFFF_FFFF);

        // Scale extremes and a write to an index that does not exist.
        settle();
        program_reg(rcsk_pkg::CFG_NSEC_SCALE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(MODE_READ, 32'h8000_0001);
        settle();
        program_reg(rcsk_pkg::CFG_NSEC_SCALE, 64'd0);
        send_event(MODE_READ, 32'h7FFF_FFFE);
        settle();
        program_reg(CFG_UNUSED_IDX, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(MODE_READ, 32'd12345);

        timer_now = 32'd2000005;
        cur_freq = 32'hFFFF_FFFF;
        random_left = RANDOM_EVENTS;
        phase = 0;
        while (random_left > 0) begin
            settle();
            if (phase == 0 || $urandom_range(0, 1)) begin
                r = $urandom_range(0, 9);
                if (r < 6) cur_freq = $urandom_range(1, 4000);
                else if (r < 8) cur_freq = $urandom_range(4001, 2000000);
                else if (r == 8) cur_freq = '0;
                else cur_freq = $urandom;
                program_reg(rcsk_pkg::CFG_TIMER_FREQ, 64'(cur_freq));
            end
            if (phase == 0 || $urandom_range(0, 1))
                program_reg(rcsk_pkg::CFG_NSEC_SCALE, $urandom_range(0, 1) ?
                            {$urandom, $urandom} : {32'($urandom_range(0, 4000)), 32'($urandom)});
            if (phase == 0 || $urandom_range(0, 1)) begin
                step = $urandom_range(0, 1) ? 18'($urandom) : 18'($urandom_range(0, 200)) - 18'd100;
                program_reg(rcsk_pkg::CFG_SLEW_STEP, 64'(step));
                // A whole number of steps lets the slew run out exactly.
                if ($urandom_range(0, 2) != 0)
                    program_reg(rcsk_pkg::CFG_SLEW_TOTAL,
                                64'(longint'($signed(step)) * $urandom_range(0, 8)));
                else
                    program_reg(rcsk_pkg::CFG_SLEW_TOTAL, {$urandom, $urandom});
            end
            if (phase == 0 || $urandom_range(0, 1))
                program_reg(rcsk_pkg::CFG_FRAC_ADJUST, $urandom_range(0, 1) ?
                            {$urandom, $urandom} :
                            {29'd0, 3'($urandom_range(0, 7)), $urandom} - 64'h4_0000_0000);
            if (phase == 0 || $urandom_range(0, 2) == 0)
                program_reg(rcsk_pkg::CFG_BASE_SEC, {$urandom, $urandom});
            if (phase == 0 || $urandom_range(0, 2) == 0)
                program_reg(rcsk_pkg::CFG_BASE_NSEC, $urandom_range(0, 3) == 0 ?
                            64'($urandom) : 64'($urandom_range(0, 999999999)));
            if ($urandom_range(0, 7) == 0)
                program_reg(CFG_UNUSED_IDX, {$urandom, $urandom});

            // One phase runs flat out into a long result hold-off so the block backs up.
            if (phase == 1) hold_requests++;
            burst_mode = (phase == 1) || ($urandom_range(0, 3) == 0);

            n = $urandom_range(30, 70);
            if (n > random_left) n = random_left;
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    if (cur_freq > 32'h7000_0000) span = $urandom;
                    else if (cur_freq == '0) span = 32'd3000;
                    else span = cur_freq + (cur_freq >> 2) + 32'd1;
                    timer_now = timer_now + 32'($urandom_range(0, span));
                    send_event($urandom_range(0, 3) == 0 ? MODE_READ : rcsk_pkg::MODE_TICK,
                               timer_now);
                end else begin
                    send_event(1'($urandom), $urandom);
                end
            end
            random_left -= n;
            burst_mode = 1'b0;
            phase++;
        end

        settle();
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rcsk_pkg.sv
hw/rtl/realtime_clock_slew_keeper.sv
test/rcsk_time_checker.sv
test/realtime_clock_slew_keeper_tb.sv
